// File: design/slfp_pkg.sv
`timescale 1ns / 1ps

package slfp_pkg;

	// Channel count and PWM period
	localparam int CHANNELS  = 6;
	localparam int PWM_STEPS = 255;

	// Width of a channel number, never below one bit
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// LED mask carries the low six channels only
	localparam int MASK_W = 6;
	localparam int LIT_CH = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Serial protocol bytes
	localparam logic [7:0] SYNC_BYTE   = 8'd255;
	localparam logic [7:0] CODE_TARGET = 8'd100;
	localparam logic [7:0] CODE_DELAY  = 8'd110;
	localparam logic [7:0] CODE_CLEAR  = 8'd120;

	// Input operations
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Parser position within a three-byte command
	typedef enum logic [1:0] {
		PS_IDLE  = 2'd0,
		PS_CODE  = 2'd1,
		PS_VALUE = 2'd2,
		PS_DONE  = 2'd3
	} parse_state_t;

	// Work that the back end carries out for one accepted word
	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_DONE   = 3'd1,
		CMD_TARGET = 3'd2,
		CMD_DELAY  = 3'd3,
		CMD_CLEAR  = 3'd4,
		CMD_TICK   = 3'd5
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t       kind;
		logic [CH_W-1:0] ch;
		logic [7:0]      value;
	} cmd_t;

endpackage

// File: design/slfp_front.sv
`timescale 1ns / 1ps

module slfp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	input  logic [7:0]    rx_byte,
	input  logic          q_ready,
	output logic          push,
	output slfp_pkg::cmd_t cmd
);

	slfp_pkg::parse_state_t state_q, state_nxt;
	logic [7:0] code_q;
	logic       is_target;
	logic       is_delay;

	// Accept a word whenever the queue has room
	assign in_ready = q_ready;
	assign push     = in_valid & q_ready;

	// Hold parser position and command code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slfp_pkg::PS_IDLE;
			code_q  <= '0;
		end else if (push && op == slfp_pkg::OP_BYTE) begin
			state_q <= state_nxt;
			if (rx_byte != slfp_pkg::SYNC_BYTE && state_q == slfp_pkg::PS_CODE) begin
				code_q <= rx_byte;
			end
		end
	end

	// Advance the parser; a sync byte always restarts it
	always_comb begin
		state_nxt = state_q;
		if (rx_byte == slfp_pkg::SYNC_BYTE) begin
			state_nxt = slfp_pkg::PS_CODE;
		end else begin
			unique case (state_q)
				slfp_pkg::PS_IDLE:  state_nxt = slfp_pkg::PS_IDLE;
				slfp_pkg::PS_CODE:  state_nxt = slfp_pkg::PS_VALUE;
				slfp_pkg::PS_VALUE: state_nxt = slfp_pkg::PS_DONE;
				slfp_pkg::PS_DONE:  state_nxt = slfp_pkg::PS_DONE;
				default:            state_nxt = slfp_pkg::PS_IDLE;
			endcase
		end
	end

	// Decode the stored code
	assign is_target = (code_q >= slfp_pkg::CODE_TARGET) &&
		(code_q < slfp_pkg::CODE_TARGET + 8'(slfp_pkg::CHANNELS));
	assign is_delay  = (code_q >= slfp_pkg::CODE_DELAY) &&
		(code_q < slfp_pkg::CODE_DELAY + 8'(slfp_pkg::CHANNELS));

	// Classify the word for the back end
	always_comb begin
		cmd.kind  = slfp_pkg::CMD_NONE;
		cmd.ch    = '0;
		cmd.value = rx_byte;
		if (op == slfp_pkg::OP_TICK) begin
			cmd.kind = slfp_pkg::CMD_TICK;
		end else if (rx_byte != slfp_pkg::SYNC_BYTE && state_q == slfp_pkg::PS_VALUE) begin
			priority if (is_target) begin
				cmd.kind = slfp_pkg::CMD_TARGET;
				cmd.ch   = slfp_pkg::CH_W'(code_q - slfp_pkg::CODE_TARGET);
			end else if (is_delay) begin
				cmd.kind = slfp_pkg::CMD_DELAY;
				cmd.ch   = slfp_pkg::CH_W'(code_q - slfp_pkg::CODE_DELAY);
			end else if (code_q == slfp_pkg::CODE_CLEAR) begin
				cmd.kind = slfp_pkg::CMD_CLEAR;
			end else begin
				cmd.kind = slfp_pkg::CMD_DONE;
			end
		end
	end

endmodule

// File: design/slfp_queue.sv
`timescale 1ns / 1ps

module slfp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  slfp_pkg::cmd_t wr_cmd,
	output logic           q_ready,
	input  logic           pop,
	output logic           q_valid,
	output slfp_pkg::cmd_t rd_cmd
);

	slfp_pkg::cmd_t                 mem_q [slfp_pkg::QDEPTH];
	logic [slfp_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [slfp_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [slfp_pkg::QCNT_W-1:0]    count_q;

	assign q_ready = count_q != slfp_pkg::QCNT_W'(slfp_pkg::QDEPTH);
	assign q_valid = count_q != '0;
	assign rd_cmd  = mem_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == slfp_pkg::QPTR_W'(slfp_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == slfp_pkg::QPTR_W'(slfp_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/slfp_back.sv
`timescale 1ns / 1ps

module slfp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  slfp_pkg::cmd_t              cmd,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [slfp_pkg::MASK_W-1:0] led_mask,
	output logic [7:0]                  pwm_phase,
	output logic                        period_end,
	output logic                        command_done
);

	localparam int CH = slfp_pkg::CHANNELS;

	// Channel state
	logic [7:0] level_q  [CH];
	logic [7:0] target_q [CH];
	logic [7:0] delay_q  [CH];
	logic [7:0] wait_q   [CH];
	logic [7:0] phase_q;

	logic [7:0] level_nxt  [CH];
	logic [7:0] target_nxt [CH];
	logic [7:0] delay_nxt  [CH];
	logic [7:0] wait_nxt   [CH];
	logic [7:0] phase_nxt;
	logic [7:0] wait_dec   [CH];
	logic [8:0] phase_inc;
	logic       wrapped;
	logic       done;
	logic [slfp_pkg::MASK_W-1:0] mask;

	logic                        out_valid_q;
	logic [slfp_pkg::MASK_W-1:0] mask_q;
	logic [7:0]                  phase_out_q;
	logic                        wrap_q;
	logic                        done_q;

	// Take the next word when the output register is free or draining
	assign pop = q_valid && (!out_valid_q || out_ready);

	assign phase_inc = {1'b0, phase_q} + 9'd1;

	// Carry out one word
	always_comb begin
		phase_nxt = phase_q;
		wrapped   = 1'b0;
		done      = 1'b0;
		for (int n = 0; n < CH; n++) begin
			level_nxt[n]  = level_q[n];
			target_nxt[n] = target_q[n];
			delay_nxt[n]  = delay_q[n];
			wait_nxt[n]   = wait_q[n];
			wait_dec[n]   = (wait_q[n] != '0) ? wait_q[n] - 8'd1 : 8'd0;
		end
		unique case (cmd.kind)
			slfp_pkg::CMD_NONE: begin
			end
			slfp_pkg::CMD_DONE: begin
				done = 1'b1;
			end
			slfp_pkg::CMD_TARGET: begin
				done = 1'b1;
				for (int n = 0; n < CH; n++) begin
					if (cmd.ch == slfp_pkg::CH_W'(n)) begin
						target_nxt[n] = cmd.value;
					end
				end
			end
			slfp_pkg::CMD_DELAY: begin
				done = 1'b1;
				for (int n = 0; n < CH; n++) begin
					if (cmd.ch == slfp_pkg::CH_W'(n)) begin
						delay_nxt[n] = cmd.value;
					end
				end
			end
			slfp_pkg::CMD_CLEAR: begin
				done = 1'b1;
				for (int n = 0; n < CH; n++) begin
					target_nxt[n] = '0;
					delay_nxt[n]  = '0;
					level_nxt[n]  = '0;
				end
			end
			slfp_pkg::CMD_TICK: begin
				if (phase_inc >= 9'(slfp_pkg::PWM_STEPS)) begin
					phase_nxt = '0;
					wrapped   = 1'b1;
					// Fade step on every channel
					for (int n = 0; n < CH; n++) begin
						wait_nxt[n] = wait_dec[n];
						if (level_q[n] != target_q[n] && wait_dec[n] == '0) begin
							wait_nxt[n]  = delay_q[n];
							level_nxt[n] = (level_q[n] > target_q[n]) ?
								level_q[n] - 8'd1 : level_q[n] + 8'd1;
						end
					end
				end else begin
					phase_nxt = phase_inc[7:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Light each channel while the phase is below its level
	always_comb begin
		mask = '0;
		for (int n = 0; n < slfp_pkg::LIT_CH; n++) begin
			mask[n] = phase_nxt < level_nxt[n];
		end
	end

	// Update channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			for (int n = 0; n < CH; n++) begin
				level_q[n]  <= '0;
				target_q[n] <= '0;
				delay_q[n]  <= '0;
				wait_q[n]   <= '0;
			end
		end else if (pop) begin
			phase_q <= phase_nxt;
			for (int n = 0; n < CH; n++) begin
				level_q[n]  <= level_nxt[n];
				target_q[n] <= target_nxt[n];
				delay_q[n]  <= delay_nxt[n];
				wait_q[n]   <= wait_nxt[n];
			end
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			mask_q      <= mask;
			phase_out_q <= phase_nxt;
			wrap_q      <= wrapped;
			done_q      <= done;
		end
	end

	assign out_valid    = out_valid_q;
	assign led_mask     = mask_q;
	assign pwm_phase    = phase_out_q;
	assign period_end   = wrap_q;
	assign command_done = done_q;

`ifndef SYNTHESIS
	a_tick_or_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(wrap_q && done_q))
		else $error("period end and command done in one word");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (phase_out_q < 8'(slfp_pkg::PWM_STEPS)))
		else $error("phase out of range");

	a_wrap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && wrap_q) |-> (phase_out_q == '0))
		else $error("period end with nonzero phase");

	a_phase_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (phase_q == phase_out_q))
		else $error("output phase differs from held phase");
`endif

endmodule

// File: design/serial_led_fader_pwm_top.sv
`timescale 1ns / 1ps

// Six-channel LED dimmer with per-channel fade. Each input word is either a
// serial byte (op 0) or a PWM tick (op 1); every word yields exactly one
// result word carrying the LED mask, the phase, a period-end flag and a
// command-done flag. Commands are sync 255, code, value: codes 100-105 set a
// target level, 110-115 a fade delay, 120 clears targets, delays and levels.
// A front end parses bytes and pushes one classified command per word into a
// two-entry queue; a back end applies it to the channel state and loads an
// output register. Throughput is one word per clock while out_ready is high;
// a stalled output register holds back the queue and then the input.
// No clearing pass after reset.

module serial_led_fader_pwm_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [slfp_pkg::MASK_W-1:0] led_mask,
	output logic [7:0]                  pwm_phase,
	output logic                        period_end,
	output logic                        command_done
);

	slfp_pkg::cmd_t front_cmd;
	slfp_pkg::cmd_t back_cmd;
	logic           push;
	logic           pop;
	logic           q_ready;
	logic           q_valid;

	slfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.rx_byte  (rx_byte),
		.q_ready  (q_ready),
		.push     (push),
		.cmd      (front_cmd)
	);

	slfp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_cmd  (front_cmd),
		.q_ready (q_ready),
		.pop     (pop),
		.q_valid (q_valid),
		.rd_cmd  (back_cmd)
	);

	slfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.cmd          (back_cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.led_mask     (led_mask),
		.pwm_phase    (pwm_phase),
		.period_end   (period_end),
		.command_done (command_done)
	);

endmodule

// File: dv/serial_led_fader_pwm_top_tb.sv
`timescale 1ns / 1ps

module serial_led_fader_pwm_top_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;

	// One result word as the block reports it
	typedef struct packed {
		logic [slfp_pkg::MASK_W-1:0] mask;
		logic [7:0]                  phase;
		logic                        wrap;
		logic                        done;
	} dimmer_word_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic                        op = slfp_pkg::OP_BYTE;
	logic [7:0]                  rx_byte = 8'd0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [slfp_pkg::MASK_W-1:0] led_mask;
	logic [7:0]                  pwm_phase;
	logic                        period_end;
	logic                        command_done;

	// Dimmer state as predicted
	slfp_pkg::parse_state_t parse_q;
	logic [7:0]   code_q;
	logic [7:0]   target_q [slfp_pkg::CHANNELS];
	logic [7:0]   delay_q  [slfp_pkg::CHANNELS];
	logic [7:0]   level_q  [slfp_pkg::CHANNELS];
	logic [7:0]   wait_q   [slfp_pkg::CHANNELS];
	logic [7:0]   phase_q;

	dimmer_word_t expected_words [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int error_count   = 0;
	int cycle_count   = 0;
	int words_sent    = 0;
	int ticks_sent    = 0;
	int wraps_seen    = 0;
	int commands_seen = 0;
	int results_seen  = 0;

	serial_led_fader_pwm_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.led_mask     (led_mask),
		.pwm_phase    (pwm_phase),
		.period_end   (period_end),
		.command_done (command_done)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Print one failure line and count it
	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Advance the dimmer state by one word and return the result it yields
	function automatic dimmer_word_t predict_dimmer(input logic op_i, input logic [7:0] b);
		dimmer_word_t w;
		logic [8:0]   nxt;
		int           n;
		w = '0;
		if (op_i == slfp_pkg::OP_BYTE) begin
			if (b == slfp_pkg::SYNC_BYTE) begin
				parse_q = slfp_pkg::PS_CODE;
			end else if (parse_q == slfp_pkg::PS_CODE) begin
				code_q  = b;
				parse_q = slfp_pkg::PS_VALUE;
			end else if (parse_q == slfp_pkg::PS_VALUE) begin
				parse_q = slfp_pkg::PS_DONE;
				w.done  = 1'b1;
				if (code_q >= slfp_pkg::CODE_TARGET &&
					code_q < slfp_pkg::CODE_TARGET + slfp_pkg::CHANNELS) begin
					target_q[slfp_pkg::CH_W'(code_q - slfp_pkg::CODE_TARGET)] = b;
				end else if (code_q >= slfp_pkg::CODE_DELAY &&
					code_q < slfp_pkg::CODE_DELAY + slfp_pkg::CHANNELS) begin
					delay_q[slfp_pkg::CH_W'(code_q - slfp_pkg::CODE_DELAY)] = b;
				end else if (code_q == slfp_pkg::CODE_CLEAR) begin
					for (n = 0; n < slfp_pkg::CHANNELS; n++) begin
						target_q[n] = 8'd0;
						delay_q[n]  = 8'd0;
						level_q[n]  = 8'd0;
					end
				end
			end
		end else begin
			nxt = {1'b0, phase_q} + 9'd1;
			if (nxt >= slfp_pkg::PWM_STEPS) begin
				phase_q = 8'd0;
				w.wrap  = 1'b1;
				// Fade step: count the wait down, then move one toward target
				for (n = 0; n < slfp_pkg::CHANNELS; n++) begin
					if (wait_q[n] != 8'd0)
						wait_q[n] = wait_q[n] - 8'd1;
					if (level_q[n] != target_q[n] && wait_q[n] == 8'd0) begin
						wait_q[n] = delay_q[n];
						if (level_q[n] > target_q[n])
							level_q[n] = level_q[n] - 8'd1;
						else
							level_q[n] = level_q[n] + 8'd1;
					end
				end
			end else begin
				phase_q = nxt[7:0];
			end
		end
		for (n = 0; n < slfp_pkg::LIT_CH; n++)
			w.mask[n] = (phase_q < level_q[n]);
		w.phase = phase_q;
		return w;
	endfunction

	// Send one word, idling first at random, and log its expected result
	task automatic send_word(input logic op_i, input logic [7:0] b);
		dimmer_word_t w;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= op_i;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		w = predict_dimmer(op_i, b);
		expected_words.push_back(w);
		words_sent++;
		if (op_i == slfp_pkg::OP_TICK)
			ticks_sent++;
		if (w.wrap)
			wraps_seen++;
		if (w.done)
			commands_seen++;
	endtask

	task automatic send_command(input logic [7:0] code, input logic [7:0] value);
		send_word(slfp_pkg::OP_BYTE, slfp_pkg::SYNC_BYTE);
		send_word(slfp_pkg::OP_BYTE, code);
		send_word(slfp_pkg::OP_BYTE, value);
	endtask

	// Field extremes, each code family, resync, ignored bytes, unknown code, clear
	task automatic test_directed();
		send_word(slfp_pkg::OP_TICK, 8'd0);
		send_command(slfp_pkg::CODE_TARGET, 8'd254);
		send_word(slfp_pkg::OP_BYTE, 8'd17);
		send_command(8'(slfp_pkg::CODE_TARGET + slfp_pkg::CHANNELS - 1), 8'd1);
		send_command(8'(slfp_pkg::CODE_DELAY + slfp_pkg::CHANNELS - 1), 8'd2);
		// sync inside a command restarts parsing
		send_word(slfp_pkg::OP_BYTE, slfp_pkg::SYNC_BYTE);
		send_word(slfp_pkg::OP_BYTE, slfp_pkg::CODE_TARGET + 8'd1);
		send_word(slfp_pkg::OP_BYTE, slfp_pkg::SYNC_BYTE);
		send_word(slfp_pkg::OP_BYTE, slfp_pkg::CODE_TARGET + 8'd4);
		send_word(slfp_pkg::OP_BYTE, 8'd9);
		send_command(8'd0, 8'd0);
		send_command(slfp_pkg::CODE_CLEAR, 8'd0);
		send_word(slfp_pkg::OP_TICK, 8'd255);
	endtask

	// Mostly tick bursts and well-formed commands, some noise and broken commands
	task automatic test_random_traffic(input int count, input int idle_pct, input int stall);
		int         pick;
		int         burst;
		int         k;
		logic [7:0] code;
		logic [7:0] value;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		k = 0;
		while (k < count) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				burst = $urandom_range(24, 1);
				repeat (burst)
					send_word(slfp_pkg::OP_TICK, 8'($urandom));
				k += burst;
			end else if (pick < 88) begin
				case ($urandom_range(19))
					0:       code = slfp_pkg::CODE_CLEAR;
					1, 2:    code = 8'($urandom);
					3, 4, 5, 6, 7, 8:
						code = slfp_pkg::CODE_DELAY +
							8'($urandom_range(slfp_pkg::CHANNELS - 1));
					default: code = slfp_pkg::CODE_TARGET +
						8'($urandom_range(slfp_pkg::CHANNELS - 1));
				endcase
				if (code >= slfp_pkg::CODE_DELAY &&
					code < slfp_pkg::CODE_DELAY + slfp_pkg::CHANNELS &&
					$urandom_range(3) != 0)
					value = 8'($urandom_range(2));
				else if ($urandom_range(15) == 0)
					value = slfp_pkg::SYNC_BYTE;
				else
					value = 8'($urandom_range(254));
				send_command(code, value);
				k += 3;
			end else if (pick < 94) begin
				// cut a command short and drop into ticks
				send_word(slfp_pkg::OP_BYTE, slfp_pkg::SYNC_BYTE);
				if ($urandom_range(1))
					send_word(slfp_pkg::OP_BYTE, slfp_pkg::CODE_TARGET +
						8'($urandom_range(slfp_pkg::CHANNELS - 1)));
				send_word(slfp_pkg::OP_TICK, 8'($urandom));
				k += 3;
			end else begin
				send_word(slfp_pkg::OP_BYTE, 8'($urandom));
				k++;
			end
		end
	endtask

	// Hold off the sender until every expected result has come back
	task automatic test_drain_pause();
		int j;
		send_idle_pct = 0;
		stall_pct     = 30;
		for (j = 0; j < 3; j++) begin
			send_command(slfp_pkg::CODE_TARGET + 8'($urandom_range(slfp_pkg::CHANNELS - 1)),
				8'($urandom_range(254)));
			repeat (6)
				send_word(slfp_pkg::OP_TICK, 8'($urandom));
			in_valid <= 1'b0;
			@(posedge clk);
			while (expected_words.size() != 0)
				@(posedge clk);
		end
	endtask

	// Drive the receiver's stall pattern
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		dimmer_word_t w;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				report_error("result word with no expectation pending");
			end else begin
				w = expected_words.pop_front();
				if (led_mask !== w.mask)
					report_error($sformatf("led_mask got %02h exp %02h", led_mask, w.mask));
				if (pwm_phase !== w.phase)
					report_error($sformatf("pwm_phase got %0d exp %0d", pwm_phase, w.phase));
				if (period_end !== w.wrap)
					report_error($sformatf("period_end got %b exp %b", period_end, w.wrap));
				if (command_done !== w.done)
					report_error($sformatf("command_done got %b exp %b", command_done, w.done));
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				expected_words.size());
			$display("serial_led_fader_pwm_top_tb: errors");
			$finish;
		end
	end

	initial begin
		int n;
		parse_q = slfp_pkg::PS_IDLE;
		code_q  = 8'd0;
		phase_q = 8'd0;
		for (n = 0; n < slfp_pkg::CHANNELS; n++) begin
			target_q[n] = 8'd0;
			delay_q[n]  = 8'd0;
			level_q[n]  = 8'd0;
			wait_q[n]   = 8'd0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(500, 0, 0);
		test_drain_pause();
		test_random_traffic(450, 70, 0);
		test_random_traffic(450, 0, 70);
		test_random_traffic(450, 20, 20);

		// Drain outstanding results, then let the pipeline settle
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_words.size() != 0)
			report_error("expected results left over at end of run");

		$display("covered %0d words (%0d ticks, %0d period wraps, %0d commands), %0d results",
			words_sent, ticks_sent, wraps_seen, commands_seen, results_seen);
		$display("idle and stall mixes: none, sender 70%%, receiver 70%%, both 20%%; %0d errors",
			error_count);
		if (error_count == 0) begin
			$display("serial_led_fader_pwm_top_tb: clean");
		end else begin
			$display("serial_led_fader_pwm_top_tb: errors");
		end
		$finish;
	end

endmodule
